>>> rtl/core/ncs_pkg.sv
// Package for the nested comment stripper: payload structs, byte codes and
// the result group passed from the scanner to the output queue. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ncs_pkg;

    localparam int DEPTH_BITS = 8;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OPEN     = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam int QUEUE_DEPTH = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       out_last;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_push;

endpackage

`default_nettype wire

>>> rtl/core/ncs_scan.sv
// Scanner for the nested comment stripper: input register, scan state and the
// single-step logic that turns one byte into up to two results. Uses ncs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ncs_scan (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  ncs_pkg::t_in_item i_item,
    input  wire [1:0]         i_space,
    output ncs_pkg::t_push    o_push
);
    import ncs_pkg::*;

    typedef enum logic [1:0] {
        MODE_TEXT  = 2'd0,
        MODE_LINE  = 2'd1,
        MODE_BLOCK = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PREV_NONE  = 2'd0,
        PREV_SLASH = 2'd1,
        PREV_STAR  = 2'd2
    } t_prev;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    logic                  r_in_valid;
    t_in_item              r_in;
    t_mode                 r_mode, n_mode;
    logic                  r_pend, n_pend;
    t_prev                 r_prev, n_prev;
    logic [DEPTH_BITS-1:0] r_depth, n_depth;
    logic                  r_ovf, n_ovf;

    logic       take;
    logic [7:0] b;
    logic [1:0] cnt;
    t_out_item  e0, e1;
    logic [1:0] st;

    function automatic t_out_item mk(input logic [7:0] val);
        t_out_item it;
        it.out_byte     = val;
        it.byte_present = 1'b1;
        it.out_last     = 1'b0;
        it.status       = ST_OK;
        return it;
    endfunction

    always_comb begin
        b       = r_in.in_byte;
        n_mode  = r_mode;
        n_pend  = r_pend;
        n_prev  = r_prev;
        n_depth = r_depth;
        n_ovf   = r_ovf;
        cnt     = 2'd0;
        e0      = '0;
        e1      = '0;
        st      = ST_OK;
        case (r_mode)
            MODE_TEXT: begin
                if (r_pend) begin
                    n_pend = 1'b0;
                    if (b == CH_SLASH) begin
                        n_mode = MODE_LINE;
                        e0     = mk(CH_SPACE);
                        cnt    = 2'd1;
                    end else if (b == CH_STAR) begin
                        n_mode  = MODE_BLOCK;
                        n_depth = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
                        n_prev  = PREV_NONE;
                    end else begin
                        e0  = mk(CH_SLASH);
                        e1  = mk(b);
                        cnt = 2'd2;
                    end
                end else if (b == CH_SLASH) begin
                    n_pend = 1'b1;
                end else begin
                    e0  = mk(b);
                    cnt = 2'd1;
                end
            end
            MODE_LINE: begin
                if (b inside {CH_LF, CH_CR, CH_NUL}) begin
                    n_mode = MODE_TEXT;
                    e0     = mk(b);
                    cnt    = 2'd1;
                end
            end
            MODE_BLOCK: begin
                if (r_prev == PREV_SLASH && b == CH_STAR) begin
                    if (r_depth == DEPTH_MAX) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_depth = r_depth + 1'b1;
                    end
                    n_prev = PREV_NONE;
                end else if (r_prev == PREV_STAR && b == CH_SLASH) begin
                    n_prev = PREV_NONE;
                    if (r_depth != '0) begin
                        n_depth = r_depth - 1'b1;
                    end
                    if (r_depth <= {{(DEPTH_BITS-1){1'b0}}, 1'b1}) begin
                        n_mode = MODE_TEXT;
                        e0     = mk(CH_SPACE);
                        cnt    = 2'd1;
                    end
                end else if (b == CH_SLASH) begin
                    n_prev = PREV_SLASH;
                end else if (b == CH_STAR) begin
                    n_prev = PREV_STAR;
                end else begin
                    n_prev = PREV_NONE;
                end
            end
            default: begin
                n_mode = MODE_TEXT;
                if (b == CH_SLASH) begin
                    n_pend = 1'b1;
                end else begin
                    e0  = mk(b);
                    cnt = 2'd1;
                end
            end
        endcase

        if (r_in.in_last) begin
            if (n_pend) begin
                if (cnt == 2'd0) begin
                    e0 = mk(CH_SLASH);
                end else begin
                    e1 = mk(CH_SLASH);
                end
                cnt = cnt + 2'd1;
            end
            if (n_ovf) begin
                st = ST_OVERFLOW;
            end else if (n_mode == MODE_BLOCK) begin
                st = ST_OPEN;
            end
            if (cnt == 2'd0) begin
                e0  = '0;
                cnt = 2'd1;
            end
            if (cnt == 2'd1) begin
                e0.out_last = 1'b1;
                e0.status   = st;
            end else begin
                e1.out_last = 1'b1;
                e1.status   = st;
            end
            n_mode  = MODE_TEXT;
            n_pend  = 1'b0;
            n_prev  = PREV_NONE;
            n_depth = '0;
            n_ovf   = 1'b0;
        end
    end

    assign take    = r_in_valid && (cnt <= i_space);
    assign o_ready = !r_in_valid || take;

    always_comb begin
        o_push.count  = take ? cnt : 2'd0;
        o_push.first  = e0;
        o_push.second = e1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_TEXT;
            r_pend     <= 1'b0;
            r_prev     <= PREV_NONE;
            r_depth    <= '0;
            r_ovf      <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (take) begin
                r_mode  <= n_mode;
                r_pend  <= n_pend;
                r_prev  <= n_prev;
                r_depth <= n_depth;
                r_ovf   <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ncs_outq.sv
// Three-entry result queue for the nested comment stripper: takes up to two
// results a cycle, delivers one while the result side is ready. Uses ncs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ncs_outq (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  ncs_pkg::t_push     i_push,
    output logic [1:0]         o_space,
    output logic               o_valid,
    input  wire                i_ready,
    output ncs_pkg::t_out_item o_res
);
    import ncs_pkg::*;

    t_out_item  r_mem [QUEUE_DEPTH];
    logic [1:0] r_head, r_tail, r_count;
    logic [1:0] n_head, n_tail, n_count;
    logic [1:0] tail1;
    logic       pop;

    function automatic logic [1:0] inc(input logic [1:0] p);
        return (p == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    assign tail1   = inc(r_tail);
    assign o_space = 2'(QUEUE_DEPTH) - r_count;
    assign o_valid = r_count != 2'd0;
    assign o_res   = r_mem[r_head];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_head  = pop ? inc(r_head) : r_head;
        n_tail  = r_tail;
        if (i_push.count == 2'd1) begin
            n_tail = tail1;
        end else if (i_push.count == 2'd2) begin
            n_tail = inc(tail1);
        end
        n_count = r_count + i_push.count - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_tail] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[tail1] <= i_push.second;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/nested_comment_stripper.sv
// Top level of the nested comment stripper: scanner followed by result queue.
// Depends on ncs_pkg, ncs_scan and ncs_outq.
//
//   channel   direction  handshake          payload
//   request   in         i_valid / o_ready  i_item (t_in_item)
//   result    out        o_valid / i_ready  o_res  (t_out_item)
//
// One byte is taken per cycle while the queue has room; it waits in the input register and
// its results then go into the queue. A request that yields two results (a flushed slash)
// is held in the input register until the three-entry result queue has room for both.
// Synchronous active-low reset returns the scan state to normal text.
// A stalled result side fills the queue, then the input register, then o_ready falls.
`timescale 1ns / 1ps
`default_nettype none

module nested_comment_stripper (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  ncs_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  wire                i_ready,
    output ncs_pkg::t_out_item o_res
);
    import ncs_pkg::*;

    t_push      push;
    logic [1:0] space;

    ncs_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .i_space (space),
        .o_push  (push)
    );

    ncs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Testbench for nested_comment_stripper. It streams directed and random source
// texts, predicts the stripped bytes and end status, and checks every result.
// Depends on ncs_pkg and the nested_comment_stripper RTL.
`timescale 1ns / 1ps

module tb_top;
    import ncs_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 100;

    class strip_scoreboard;
        typedef enum logic [1:0] {SCAN_TEXT, SCAN_LINE, SCAN_BLOCK} scan_e;
        typedef enum logic [1:0] {MARK_NONE, MARK_SLASH, MARK_STAR} mark_e;

        scan_e                 mode;
        logic                  slash_held;
        mark_e                 mark;
        logic [DEPTH_BITS-1:0] depth;
        logic                  overflowed;
        t_out_item             expected_out[$];
        t_out_item             step_out[$];
        int                    mismatches;

        function new();
            clear_state();
            mismatches = 0;
        endfunction

        function void clear_state();
            mode       = SCAN_TEXT;
            slash_held = 1'b0;
            mark       = MARK_NONE;
            depth      = '0;
            overflowed = 1'b0;
        endfunction

        function void emit(logic [7:0] b);
            t_out_item r;
            r = '0;
            r.out_byte     = b;
            r.byte_present = 1'b1;
            step_out.push_back(r);
        endfunction

        function void note_request(t_in_item req);
            logic [7:0] b;
            t_out_item  tail;
            b = req.in_byte;
            step_out.delete();
            case (mode)
                SCAN_TEXT: begin
                    if (slash_held) begin
                        slash_held = 1'b0;
                        if (b == CH_SLASH) begin
                            mode = SCAN_LINE;
                            emit(CH_SPACE);
                        end else if (b == CH_STAR) begin
                            mode  = SCAN_BLOCK;
                            depth = DEPTH_BITS'(1);
                            mark  = MARK_NONE;
                        end else begin
                            emit(CH_SLASH);
                            emit(b);
                        end
                    end else if (b == CH_SLASH) begin
                        slash_held = 1'b1;
                    end else begin
                        emit(b);
                    end
                end
                SCAN_LINE: begin
                    if (b == CH_LF || b == CH_CR || b == CH_NUL) begin
                        mode = SCAN_TEXT;
                        emit(b);
                    end
                end
                default: begin
                    if (mark == MARK_SLASH && b == CH_STAR) begin
                        if (&depth)
                            overflowed = 1'b1;
                        else
                            depth = depth + 1'b1;
                        mark = MARK_NONE;
                    end else if (mark == MARK_STAR && b == CH_SLASH) begin
                        mark = MARK_NONE;
                        if (depth != 0)
                            depth = depth - 1'b1;
                        if (depth == 0) begin
                            mode = SCAN_TEXT;
                            emit(CH_SPACE);
                        end
                    end else if (b == CH_SLASH) begin
                        mark = MARK_SLASH;
                    end else if (b == CH_STAR) begin
                        mark = MARK_STAR;
                    end else begin
                        mark = MARK_NONE;
                    end
                end
            endcase
            if (req.in_last) begin
                if (slash_held)
                    emit(CH_SLASH);
                if (step_out.size() == 0)
                    step_out.push_back(t_out_item'('0));
                tail = step_out.pop_back();
                tail.out_last = 1'b1;
                tail.status   = overflowed ? ST_OVERFLOW :
                                (mode == SCAN_BLOCK) ? ST_OPEN : ST_OK;
                step_out.push_back(tail);
                clear_state();
            end
            foreach (step_out[k])
                expected_out.push_back(step_out[k]);
        endfunction

        function void report(string what, t_out_item want, t_out_item got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t %s: expected byte %h present %b last %b status %0d",
                         $time, what, want.out_byte, want.byte_present, want.out_last,
                         want.status);
                $display("    got byte %h present %b last %b status %0d",
                         got.out_byte, got.byte_present, got.out_last, got.status);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_out.size() == 0) begin
                report("unexpected result", '0, got);
                return;
            end
            want = expected_out.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_present !== want.byte_present ||
                got.out_last !== want.out_last || got.status !== want.status)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_ready = 1'b0;
    t_in_item  i_item  = '0;
    logic      o_ready;
    logic      o_valid;
    t_out_item o_res;

    strip_scoreboard sb = new();
    t_in_item        stim_q[$];
    int              send_idle_pct  = 16;
    int              recv_stall_pct = 59;
    int              quiet_cycles   = 0;

    nested_comment_stripper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_res);
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic add_byte(input logic [7:0] b);
        t_in_item item;
        item.in_byte = b;
        item.in_last = 1'b0;
        stim_q.push_back(item);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic end_text();
        t_in_item item;
        item = stim_q.pop_back();
        item.in_last = 1'b1;
        stim_q.push_back(item);
    endtask

    function automatic logic [7:0] any_but_slash();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_SLASH);
        return b;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_SLASH || b == CH_STAR);
        return b;
    endfunction

    function automatic logic [7:0] line_filler();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_LF || b == CH_CR || b == CH_NUL);
        return b;
    endfunction

    task automatic add_line_comment(input bit closed);
        add_str("//");
        repeat ($urandom_range(5))
            add_byte(line_filler());
        if (closed) begin
            case ($urandom_range(2))
                0: add_byte(CH_LF);
                1: add_byte(CH_CR);
                default: add_byte(CH_NUL);
            endcase
        end
    endtask

    task automatic add_block(input int levels, input bit closed);
        add_str("/*");
        repeat ($urandom_range(3)) begin
            case ($urandom_range(3))
                0: begin
                    add_byte(CH_STAR);
                    add_byte(plain_byte());
                end
                1: begin
                    add_byte(CH_SLASH);
                    add_byte(plain_byte());
                end
                2: begin
                    if (levels > 0)
                        add_block(levels - 1, 1'b1);
                    else
                        add_byte(plain_byte());
                end
                default: repeat ($urandom_range(3, 1)) add_byte(plain_byte());
            endcase
        end
        if (closed)
            add_str("*/");
    endtask

    task automatic gen_text();
        int kind;
        kind = $urandom_range(99);
        if (kind < 12) begin
            repeat ($urandom_range(20, 1)) begin
                case ($urandom_range(4))
                    0: add_byte(CH_SLASH);
                    1: add_byte(CH_STAR);
                    2: add_byte(CH_LF);
                    default: add_byte(8'($urandom_range(255)));
                endcase
            end
        end else begin
            repeat ($urandom_range(6, 1)) begin
                case ($urandom_range(4))
                    0, 1: repeat ($urandom_range(4, 1)) add_byte(any_but_slash());
                    2: add_line_comment(1'b1);
                    3: add_block($urandom_range(3), 1'b1);
                    default: begin
                        add_byte(CH_SLASH);
                        add_byte(plain_byte());
                    end
                endcase
            end
            if (kind < 30) begin
                case ($urandom_range(2))
                    0: add_block($urandom_range(2), 1'b0);
                    1: add_line_comment(1'b0);
                    default: add_byte(CH_SLASH);
                endcase
            end
        end
        end_text();
    endtask

    task automatic send_request(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= item;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(item);
    endtask

    initial begin
        int total;

        add_byte(CH_NUL);
        add_byte(8'hFF);
        end_text();
        add_byte(CH_SLASH);
        end_text();
        add_byte(CH_SLASH);
        add_byte("q");
        end_text();
        add_str("//");
        add_byte(CH_CR);
        add_str("//");
        add_byte(CH_NUL);
        add_str("//x");
        end_text();
        add_str("/*/**/*/");
        add_byte(CH_LF);
        end_text();
        add_str("/*");
        end_text();

        total = stim_q.size();
        while (stim_q.size() < total + RANDOM_ITEMS / 2)
            gen_text();
        // Saturate the depth counter, then close two levels while still inside the comment.
        repeat (1 << DEPTH_BITS) add_str("/*");
        repeat (2) add_str("*/");
        end_text();
        total = stim_q.size();
        while (stim_q.size() < total + RANDOM_ITEMS / 2)
            gen_text();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        total = stim_q.size();
        for (int k = 0; k < total; k++) begin
            if (k < total / 3) begin
                send_idle_pct  = 16;
                recv_stall_pct = 59;
            end else if (k < 2 * total / 3) begin
                send_idle_pct  = 59;
                recv_stall_pct = 16;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            send_request(stim_q[k]);
        end
        i_valid <= 1'b0;

        while (sb.expected_out.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_out.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
